FILE: hw/rtl/token_gated_mutex_with_wait_queue_macros.svh
// Assertion helpers shared by the mutex RTL. Both sample on clk_i and are
// disabled while rst_ni is low.
`ifndef TOKEN_GATED_MUTEX_WITH_WAIT_QUEUE_MACROS_SVH
`define TOKEN_GATED_MUTEX_WITH_WAIT_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tgm_pkg.sv
package tgm_pkg;

  // Lock request, unlock and force unlock codes as they arrive on action_i.
  typedef enum logic [1:0] {
    ACT_LOCK   = 2'd0,
    ACT_UNLOCK = 2'd1,
    ACT_FORCE  = 2'd2
  } action_e;

  // Classified command handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_BAD    = 2'd0,
    OP_LOCK   = 2'd1,
    OP_UNLOCK = 2'd2,
    OP_FORCE  = 2'd3
  } cmd_op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_BAD_TOKEN = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_FORCED    = 3'd6
  } status_e;

  // Handshake between the command queue and the back end.
  typedef struct packed {
    logic    valid;
    cmd_op_e op;
  } cmd_ctl_t;

  localparam int unsigned ProofWidth = 64;

endpackage

FILE: hw/rtl/tgm_ram.sv
module tgm_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tgm_front.sv
`include "token_gated_mutex_with_wait_queue_macros.svh"

module tgm_front #(
  parameter int unsigned PID_WIDTH = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       action_i,
  input  logic [PID_WIDTH-1:0]             pid_i,
  input  logic [tgm_pkg::ProofWidth-1:0]   proof_i,
  output tgm_pkg::cmd_ctl_t                cmd_o,
  output logic [PID_WIDTH-1:0]             cmd_pid_o,
  input  logic                             pop_i
);
  import tgm_pkg::*;

  // Two-entry command queue between classification and execution.
  cmd_op_e              op_q  [2];
  logic [PID_WIDTH-1:0] pid_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;

  cmd_op_e op_d;
  logic    known;
  logic    push;

  always_comb begin
    op_d  = OP_BAD;
    known = 1'b1;
    unique case (action_i)
      ACT_LOCK:   op_d = (proof_i == '0) ? OP_BAD : OP_LOCK;
      ACT_UNLOCK: op_d = OP_UNLOCK;
      ACT_FORCE:  op_d = OP_FORCE;
      default:    known = 1'b0;
    endcase
  end

  assign busy = (cnt_q == 2'd2);
  // Unknown action codes are accepted and dropped here.
  assign push = start && !busy && known;

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= op_d;
      pid_q[wr_ptr_q] <= pid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  assign cmd_o.valid = (cnt_q != 2'd0);
  assign cmd_o.op    = op_q[rd_ptr_q];
  assign cmd_pid_o   = pid_q[rd_ptr_q];

  `TGM_ASSERT_NOW(a_pop_nonempty, pop_i, cnt_q != 2'd0, "command popped from an empty queue")
  `TGM_ASSERT_NEXT(a_full_holds, busy && !pop_i, busy, "queue lost an entry without a pop")
  `TGM_ASSERT_NOW(a_busy_no_push, busy, !push, "command pushed into a full queue")

endmodule

FILE: hw/rtl/tgm_back.sv
`include "token_gated_mutex_with_wait_queue_macros.svh"

module tgm_back #(
  parameter int unsigned WAITER_DEPTH = 16,
  parameter int unsigned PID_WIDTH    = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tgm_pkg::cmd_ctl_t    cmd_i,
  input  logic [PID_WIDTH-1:0] cmd_pid_i,
  output logic                 pop_o,
  output logic                 strobe_o,
  output logic [2:0]           status_o,
  output logic                 notify_valid_o,
  output logic [PID_WIDTH-1:0] notify_pid_o,
  output logic [PID_WIDTH-1:0] block_owner_o,
  output logic                 wake_valid_o,
  output logic [PID_WIDTH-1:0] wake_pid_o,
  output logic                 last_o
);
  import tgm_pkg::*;

  localparam int unsigned AW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WAITER_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_UNLK  = 3'b010,
    S_FORCE = 3'b100
  } state_e;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(WAITER_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(WAITER_DEPTH - 1) : p - AW'(1);
  endfunction

  state_e               state_q, state_d;
  // One flag covers both "held" and "owner present"; they always change together.
  logic                 held_q, held_d;
  logic [PID_WIDTH-1:0] owner_q, owner_d;
  logic [AW-1:0]        head_q, head_d, tail_q, tail_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]        count_q, count_d, left_q, left_d;
  logic                 evict_v_q, evict_v_d;
  logic [PID_WIDTH-1:0] evict_pid_q, evict_pid_d;

  logic                 strobe_q, strobe_d;
  status_e              status_q, status_d;
  logic                 nv_q, nv_d, wv_q, wv_d, last_q, last_d;
  logic [PID_WIDTH-1:0] np_q, np_d, bo_q, bo_d, wp_q, wp_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [PID_WIDTH-1:0] ram_rdata;

  tgm_ram #(
    .WIDTH (PID_WIDTH),
    .DEPTH (WAITER_DEPTH)
  ) u_waiters (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (cmd_pid_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    owner_d     = owner_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rd_ptr_d    = rd_ptr_q;
    count_d     = count_q;
    left_d      = left_q;
    evict_v_d   = evict_v_q;
    evict_pid_d = evict_pid_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = head_q;
    strobe_d    = 1'b0;
    status_d    = ST_GRANTED;
    nv_d        = 1'b0;
    np_d        = '0;
    bo_d        = '0;
    wv_d        = 1'b0;
    wp_d        = '0;
    last_d      = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_BAD: begin
              strobe_d = 1'b1;
              status_d = ST_BAD_TOKEN;
            end
            OP_LOCK: begin
              strobe_d = 1'b1;
              if (!held_q) begin
                held_d   = 1'b1;
                owner_d  = cmd_pid_i;
                status_d = ST_GRANTED;
                nv_d     = 1'b1;
                np_d     = cmd_pid_i;
              end else if (count_q < CW'(WAITER_DEPTH)) begin
                ram_we   = 1'b1;
                tail_d   = ptr_inc(tail_q);
                count_d  = count_q + CW'(1);
                status_d = ST_QUEUED;
                bo_d     = owner_q;
              end else begin
                status_d = ST_FULL;
              end
            end
            OP_UNLOCK: begin
              if (!held_q || owner_q != cmd_pid_i) begin
                strobe_d = 1'b1;
                status_d = ST_NOT_OWNER;
              end else begin
                held_d  = 1'b0;
                owner_d = '0;
                if (count_q != '0) begin
                  // Fetch the head waiter; the result goes out once it is read.
                  ram_raddr   = head_q;
                  head_d      = ptr_inc(head_q);
                  count_d     = count_q - CW'(1);
                  evict_pid_d = cmd_pid_i;
                  state_d     = S_UNLK;
                end else begin
                  strobe_d = 1'b1;
                  status_d = ST_RELEASED;
                  nv_d     = 1'b1;
                  np_d     = cmd_pid_i;
                end
              end
            end
            OP_FORCE: begin
              held_d  = 1'b0;
              owner_d = '0;
              count_d = '0;
              head_d  = tail_q;
              if (count_q == '0) begin
                strobe_d = 1'b1;
                status_d = ST_FORCED;
                nv_d     = held_q;
                np_d     = owner_q;
              end else begin
                // Walk the queue from the newest entry back to the oldest.
                ram_raddr   = ptr_dec(tail_q);
                rd_ptr_d    = ptr_dec(ptr_dec(tail_q));
                left_d      = count_q;
                evict_v_d   = held_q;
                evict_pid_d = owner_q;
                state_d     = S_FORCE;
              end
            end
            default: ;
          endcase
        end
      end
      S_UNLK: begin
        strobe_d = 1'b1;
        status_d = ST_RELEASED;
        nv_d     = 1'b1;
        np_d     = evict_pid_q;
        wv_d     = 1'b1;
        wp_d     = ram_rdata;
        state_d  = S_IDLE;
      end
      S_FORCE: begin
        strobe_d    = 1'b1;
        status_d    = ST_FORCED;
        nv_d        = evict_v_q;
        np_d        = evict_pid_q;
        wv_d        = 1'b1;
        wp_d        = ram_rdata;
        last_d      = (left_q == CW'(1));
        evict_v_d   = 1'b0;
        evict_pid_d = '0;
        ram_raddr   = rd_ptr_q;
        rd_ptr_d    = ptr_dec(rd_ptr_q);
        left_d      = left_q - CW'(1);
        if (left_q == CW'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      held_q    <= 1'b0;
      owner_q   <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      left_q    <= '0;
      evict_v_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      owner_q   <= owner_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      left_q    <= left_d;
      evict_v_q <= evict_v_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q    <= rd_ptr_d;
    evict_pid_q <= evict_pid_d;
    status_q    <= status_d;
    nv_q        <= nv_d;
    np_q        <= np_d;
    bo_q        <= bo_d;
    wv_q        <= wv_d;
    wp_q        <= wp_d;
    last_q      <= last_d;
  end

  assign strobe_o       = strobe_q;
  assign status_o       = status_q;
  assign notify_valid_o = nv_q;
  assign notify_pid_o   = np_q;
  assign block_owner_o  = bo_q;
  assign wake_valid_o   = wv_q;
  assign wake_pid_o     = wp_q;
  assign last_o         = last_q;

  `TGM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(WAITER_DEPTH), "waiter count above depth")
  `TGM_ASSERT_NOW(a_force_clear, state_q == S_FORCE, !held_q && count_q == '0, "force walk with live state")
  `TGM_ASSERT_NEXT(a_force_end, state_q == S_FORCE && left_q == CW'(1), state_q == S_IDLE && last_o, "force walk did not end")
  `TGM_ASSERT_NOW(a_no_pop_busy, state_q != S_IDLE, !pop_o, "command taken while an item is in flight")

endmodule

FILE: hw/rtl/token_gated_mutex_with_wait_queue.sv
// Hardware mutex with a FIFO of waiting process ids. A command is taken when
// start is high and busy is low; every result word is shown on the result
// ports for exactly one cycle with strobe_o high, and the receiver cannot
// stall it, so it must take each word in the cycle it appears. An accepted
// word is first written into the command queue, and its result is then held
// in the registered result ports. Lock requests, bad tokens, refused unlocks
// and unlocks with an empty queue complete from the idle state of the
// execution unit; an unlock that wakes a waiter passes through the S_UNLK
// state as well, since the head waiter is read from the waiter RAM with a
// registered read. A force unlock with no waiters gives a single word. With
// waiters it starts the walk from the idle state, then gives one word per
// cycle, newest waiter first, with last_o on the final word. Commands run one
// at a time in the execution unit; a two-entry command queue in front of it
// lets two more commands be accepted while one is executing, and busy rises
// while that queue is full. Unknown action codes are accepted and dropped
// without a result. The waiter RAM needs no clearing: only entries between
// the head and tail pointers are ever used.
module token_gated_mutex_with_wait_queue #(
  parameter int unsigned WAITER_DEPTH = 16,
  parameter int unsigned PID_WIDTH    = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     action_i,
  input  logic [PID_WIDTH-1:0]           pid_i,
  input  logic [tgm_pkg::ProofWidth-1:0] proof_i,
  output logic                           strobe_o,
  output logic [2:0]                     status_o,
  output logic                           notify_valid_o,
  output logic [PID_WIDTH-1:0]           notify_pid_o,
  output logic [PID_WIDTH-1:0]           block_owner_o,
  output logic                           wake_valid_o,
  output logic [PID_WIDTH-1:0]           wake_pid_o,
  output logic                           last_o
);
  import tgm_pkg::*;

  // Classified command at the head of the queue, with its pid.
  cmd_ctl_t             cmd;
  logic [PID_WIDTH-1:0] cmd_pid;
  logic                 pop;

  // The front end checks the proof and decodes the action, then queues it.
  tgm_front #(
    .PID_WIDTH (PID_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .action_i  (action_i),
    .pid_i     (pid_i),
    .proof_i   (proof_i),
    .cmd_o     (cmd),
    .cmd_pid_o (cmd_pid),
    .pop_i     (pop)
  );

  // The back end owns the lock state and the waiter queue and drives the
  // registered result ports.
  tgm_back #(
    .WAITER_DEPTH (WAITER_DEPTH),
    .PID_WIDTH    (PID_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cmd_pid_i      (cmd_pid),
    .pop_o          (pop),
    .strobe_o       (strobe_o),
    .status_o       (status_o),
    .notify_valid_o (notify_valid_o),
    .notify_pid_o   (notify_pid_o),
    .block_owner_o  (block_owner_o),
    .wake_valid_o   (wake_valid_o),
    .wake_pid_o     (wake_pid_o),
    .last_o         (last_o)
  );

endmodule
